// ===== design/touch_button_cycle_controller_core_defines.svh =====
// Assertion macros for the touch button cycle controller core.
`ifndef TOUCH_BUTTON_CYCLE_CONTROLLER_CORE_DEFINES_SVH
`define TOUCH_BUTTON_CYCLE_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TBCC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tbcc assertion failed");

// next-cycle implication, disabled during reset
`define TBCC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tbcc assertion failed");

`endif

// ===== design/tbcc_pkg.sv =====
// Types, constants and the variant table of the touch button cycle controller.
package tbcc_pkg;

   localparam int PAD_COUNT   = 3;
   localparam int SHOW_COUNT  = 11;
   localparam int LAYOUT_BITS = 3;

   localparam logic [1:0] CSR_ENABLE    = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_DEBOUNCE  = 2'd2;

   localparam logic [15:0] DEBOUNCE_RESET = 16'd300;

   typedef enum logic [1:0] {
      ACT_SHOW    = 2'd0,
      ACT_VARIANT = 2'd1,
      ACT_LAYOUT  = 2'd2
   } action_type;

   typedef struct packed {
      logic        enable;
      logic [15:0] threshold;
      logic [15:0] debounce;
   } cfg_type;

   // one queued tick: which pads had an accepted press
   typedef struct packed {
      logic                 valid;
      logic [PAD_COUNT-1:0] mask;
   } press_word_type;

   function automatic logic [3:0] variant_count(input logic [3:0] show);
      logic [3:0] count;
      case (show)
         4'd0:    count = 4'd13;
         4'd1:    count = 4'd3;
         4'd2:    count = 4'd3;
         4'd3:    count = 4'd1;
         4'd4:    count = 4'd1;
         4'd5:    count = 4'd3;
         4'd6:    count = 4'd1;
         4'd7:    count = 4'd2;
         4'd8:    count = 4'd2;
         4'd9:    count = 4'd3;
         4'd10:   count = 4'd2;
         default: count = 4'd1;
      endcase
      return count;
   endfunction

endpackage

// ===== design/tbcc_front.sv =====
// Front end: edge detect and debounce of the pads, one press mask per tick.
module tbcc_front
   import tbcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [31:0]           req_time_ms,
   input  logic [15:0]           req_pad0_reading,
   input  logic [15:0]           req_pad1_reading,
   input  logic [15:0]           req_pad2_reading,
   input  logic                  push_ready,
   output press_word_type        push
);

   logic [PAD_COUNT-1:0] was_touched_ff, was_touched_in;
   logic [31:0]          last_press_ff [PAD_COUNT];
   logic [31:0]          last_press_in [PAD_COUNT];
   logic [15:0]          reading [PAD_COUNT];
   logic [PAD_COUNT-1:0] touched;
   logic [PAD_COUNT-1:0] press;
   logic [31:0]          elapsed [PAD_COUNT];
   logic                 take;

   assign reading[0] = req_pad0_reading;
   assign reading[1] = req_pad1_reading;
   assign reading[2] = req_pad2_reading;

   assign req_ready = push_ready;
   assign take      = req_valid && req_ready && cfg.enable;

   always_comb begin
      was_touched_in = was_touched_ff;
      for (int i = 0; i < PAD_COUNT; i++) begin
         touched[i]       = reading[i] > cfg.threshold;
         elapsed[i]       = req_time_ms - last_press_ff[i];
         press[i]         = touched[i] && !was_touched_ff[i] &&
                            (elapsed[i] >= {16'd0, cfg.debounce});
         last_press_in[i] = last_press_ff[i];
         if (take) begin
            was_touched_in[i] = touched[i];
            if (press[i]) begin
               last_press_in[i] = req_time_ms;
            end
         end
      end
      push.valid = take && (press != '0);
      push.mask  = press;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         was_touched_ff <= '0;
         for (int i = 0; i < PAD_COUNT; i++) begin
            last_press_ff[i] <= '0;
         end
      end else begin
         was_touched_ff <= was_touched_in;
         for (int i = 0; i < PAD_COUNT; i++) begin
            last_press_ff[i] <= last_press_in[i];
         end
      end
   end

endmodule

// ===== design/tbcc_queue.sv =====
// Short queue of press masks between the front and back ends.
module tbcc_queue
   import tbcc_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic           clock,
   input  logic           reset,
   input  press_word_type push,
   output logic           push_ready,
   output press_word_type head,
   input  logic           pop
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL      = CW'(DEPTH);

   logic [PAD_COUNT-1:0] slot_ff [DEPTH];
   logic [PW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = count_ff != FULL;
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = count_ff != '0;
   assign head.mask  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.mask;
      end
   end

endmodule

// ===== design/tbcc_back.sv =====
// Back end: steps show, variant and layout, one result word per press.
module tbcc_back
   import tbcc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  press_word_type         head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_action,
   output logic [3:0]             rsp_show_number,
   output logic [3:0]             rsp_variant_number,
   output logic [LAYOUT_BITS-1:0] rsp_layout_number,
   output logic                   rsp_reverse_flag,
   output logic                   rsp_mirror_flag,
   output logic                   rsp_last
);

   localparam logic [4:0] SHOW_WRAP = 5'(SHOW_COUNT);

   logic [PAD_COUNT-1:0]   cur_mask_ff, cur_mask_in;
   logic [3:0]             show_ff, show_in;
   logic [3:0]             variant_ff, variant_in;
   logic [LAYOUT_BITS-1:0] layout_ff, layout_in;
   logic                   out_valid_ff, out_valid_in;
   action_type             out_action_ff, out_action_in;
   logic                   out_last_ff, out_last_in;

   logic [PAD_COUNT-1:0]   pick, rest;
   logic                   out_free, step;
   logic [4:0]             show_inc, variant_inc, vcount;

   always_comb begin
      pick = '0;
      for (int i = PAD_COUNT - 1; i >= 0; i--) begin
         if (cur_mask_ff[i]) begin
            pick    = '0;
            pick[i] = 1'b1;
         end
      end
      rest     = cur_mask_ff & ~pick;
      out_free = !out_valid_ff || rsp_ready;
      step     = (cur_mask_ff != '0) && out_free;

      show_inc    = {1'b0, show_ff} + 5'd1;
      variant_inc = {1'b0, variant_ff} + 5'd1;
      vcount      = {1'b0, variant_count(show_ff)};

      show_in       = show_ff;
      variant_in    = variant_ff;
      layout_in     = layout_ff;
      out_action_in = out_action_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      cur_mask_in   = cur_mask_ff;

      if (step) begin
         out_valid_in = 1'b1;
         out_last_in  = rest == '0;
         cur_mask_in  = rest;
         if (pick[0]) begin
            show_in       = (show_inc >= SHOW_WRAP) ? 4'd0 : show_inc[3:0];
            variant_in    = 4'd0;
            out_action_in = ACT_SHOW;
         end else if (pick[1]) begin
            variant_in    = (variant_inc >= vcount) ? 4'(variant_inc - vcount)
                                                    : variant_inc[3:0];
            out_action_in = ACT_VARIANT;
         end else begin
            layout_in     = layout_ff + LAYOUT_BITS'(1);
            out_action_in = ACT_LAYOUT;
         end
      end

      pop = head.valid && ((cur_mask_ff == '0) || (step && rest == '0));
      if (pop) begin
         cur_mask_in = head.mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_mask_ff  <= '0;
         show_ff      <= '0;
         variant_ff   <= '0;
         layout_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_mask_ff  <= cur_mask_in;
         show_ff      <= show_in;
         variant_ff   <= variant_in;
         layout_ff    <= layout_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_action_ff <= out_action_in;
      out_last_ff   <= out_last_in;
   end

   // state registers only change on a step, so they hold the word's values
   assign rsp_valid          = out_valid_ff;
   assign rsp_action         = out_action_ff;
   assign rsp_show_number    = show_ff;
   assign rsp_variant_number = variant_ff;
   assign rsp_layout_number  = layout_ff;
   assign rsp_reverse_flag   = layout_ff[1];
   assign rsp_mirror_flag    = layout_ff[0];
   assign rsp_last           = out_last_ff;

endmodule

// ===== design/touch_button_cycle_controller_core.sv =====
// Top level of the touch button cycle controller: CSRs, front, queue and back.
//
//  channel | dir | handshake             | payload
//  csr     | in  | csr_valid, csr_ready  | csr_index, csr_data
//  req     | in  | req_valid, req_ready  | time_ms, pad0..pad2 readings
//  rsp     | out | rsp_valid, rsp_ready  | action, show/variant/layout, flags, last
//
// A req word is taken every cycle while the press queue has room; the front
// end decides all presses of a tick in the cycle it is accepted.
// The back end gives one rsp word per cycle while rsp_ready is high, one per press
// of a tick; the queue of QUEUE_DEPTH ticks absorbs bursts. Reset is synchronous
// and clears all but queue slots, rsp action and last; csr_ready is always high.
// A stalled rsp word holds while the front keeps accepting until the queue fills.
`include "touch_button_cycle_controller_core_defines.svh"

module touch_button_cycle_controller_core
   import tbcc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_time_ms,
   input  logic [15:0] req_pad0_reading,
   input  logic [15:0] req_pad1_reading,
   input  logic [15:0] req_pad2_reading,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_action,
   output logic [3:0]  rsp_show_number,
   output logic [3:0]  rsp_variant_number,
   output logic [2:0]  rsp_layout_number,
   output logic        rsp_reverse_flag,
   output logic        rsp_mirror_flag,
   output logic        rsp_last
);

   cfg_type        cfg_ff, cfg_in;
   press_word_type push, head;
   logic           push_ready, pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ENABLE:    cfg_in.enable    = csr_data[0];
            CSR_THRESHOLD: cfg_in.threshold = csr_data;
            CSR_DEBOUNCE:  cfg_in.debounce  = csr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable    <= 1'b0;
         cfg_ff.threshold <= '0;
         cfg_ff.debounce  <= DEBOUNCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tbcc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_time_ms      (req_time_ms),
      .req_pad0_reading (req_pad0_reading),
      .req_pad1_reading (req_pad1_reading),
      .req_pad2_reading (req_pad2_reading),
      .push_ready       (push_ready),
      .push             (push)
   );

   tbcc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   tbcc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_action         (rsp_action),
      .rsp_show_number    (rsp_show_number),
      .rsp_variant_number (rsp_variant_number),
      .rsp_layout_number  (rsp_layout_number),
      .rsp_reverse_flag   (rsp_reverse_flag),
      .rsp_mirror_flag    (rsp_mirror_flag),
      .rsp_last           (rsp_last)
   );

   `TBCC_ASSERT_NOW(a_show_range, rsp_valid, rsp_show_number < 4'(SHOW_COUNT))
   `TBCC_ASSERT_NOW(a_show_clears_variant, rsp_valid && rsp_action == ACT_SHOW,
      rsp_variant_number == 4'd0)
   `TBCC_ASSERT_NOW(a_variant_range, rsp_valid,
      rsp_variant_number < variant_count(rsp_show_number))
   `TBCC_ASSERT_NEXT(a_tick_words_follow, rsp_valid && rsp_ready && !rsp_last, rsp_valid)

endmodule

// ===== sim/touch_button_cycle_controller_core_tb.sv =====
// Self-checking testbench for the touch button cycle controller core.
`timescale 1ns / 100ps

module touch_button_cycle_controller_core_tb
   import tbcc_pkg::*;
();

   localparam logic [1:0]  CSR_UNUSED     = 2'd3;
   localparam int          SETTLE_CYCLES  = 16;
   // variants per show, show 0 in the low nibble; shows 11..15 have one
   localparam logic [63:0] VARIANT_COUNTS = 64'h1111_1232_2131_133D;

   typedef struct packed {
      action_type  action;
      logic [3:0]  show;
      logic [3:0]  variant;
      logic [2:0]  layout;
      logic        reverse;
      logic        mirror;
      logic        last;
   } press_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_time_ms = '0;
   logic [15:0] req_pad0_reading = '0;
   logic [15:0] req_pad1_reading = '0;
   logic [15:0] req_pad2_reading = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_action;
   logic [3:0]  rsp_show_number;
   logic [3:0]  rsp_variant_number;
   logic [2:0]  rsp_layout_number;
   logic        rsp_reverse_flag;
   logic        rsp_mirror_flag;
   logic        rsp_last;

   // predictor state
   logic                 cfg_enable = 1'b0;
   logic [15:0]          cfg_threshold = '0;
   logic [15:0]          cfg_debounce = DEBOUNCE_RESET;
   logic [PAD_COUNT-1:0] pad_held = '0;
   logic [31:0]          press_stamp [PAD_COUNT];
   logic [3:0]           show_pos = '0;
   logic [3:0]           variant_pos = '0;
   logic [2:0]           layout_pos = '0;

   press_result_type     expected_presses [$];
   press_result_type     head_press;
   int                   error_count = 0;
   bit                   steady_tail = 1'b0;
   logic [31:0]          sim_ms = '0;
   logic [PAD_COUNT-1:0] touch_plan = '0;

   touch_button_cycle_controller_core dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_time_ms        (req_time_ms),
      .req_pad0_reading   (req_pad0_reading),
      .req_pad1_reading   (req_pad1_reading),
      .req_pad2_reading   (req_pad2_reading),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_action         (rsp_action),
      .rsp_show_number    (rsp_show_number),
      .rsp_variant_number (rsp_variant_number),
      .rsp_layout_number  (rsp_layout_number),
      .rsp_reverse_flag   (rsp_reverse_flag),
      .rsp_mirror_flag    (rsp_mirror_flag),
      .rsp_last           (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("touch_button_cycle_controller_core_tb NOT OK");
      $finish;
   end

   // presses accepted by one tick, in pad order
   task automatic predict_presses(input logic [31:0] now, input logic [15:0] r0,
                                  input logic [15:0] r1, input logic [15:0] r2);
      logic [15:0]      reading [PAD_COUNT];
      logic [31:0]      elapsed;
      logic             touched;
      press_result_type found [$];
      press_result_type word;
      foreach (reading[k]) reading[k] = '0;
      reading[0] = r0;
      reading[1] = r1;
      reading[2] = r2;
      if (!cfg_enable) return;
      for (int i = 0; i < PAD_COUNT; i++) begin
         touched = reading[i] > cfg_threshold;
         elapsed = now - press_stamp[i];
         if (touched && !pad_held[i] && elapsed >= {16'd0, cfg_debounce}) begin
            press_stamp[i] = now;
            case (i)
               0: begin
                  show_pos    = 4'((int'(show_pos) + 1) % SHOW_COUNT);
                  variant_pos = '0;
                  word.action = ACT_SHOW;
               end
               1: begin
                  variant_pos = 4'((int'(variant_pos) + 1) %
                                   int'(VARIANT_COUNTS[show_pos*4 +: 4]));
                  word.action = ACT_VARIANT;
               end
               default: begin
                  layout_pos  = layout_pos + 3'd1;
                  word.action = ACT_LAYOUT;
               end
            endcase
            word.show    = show_pos;
            word.variant = variant_pos;
            word.layout  = layout_pos;
            word.reverse = layout_pos[1];
            word.mirror  = layout_pos[0];
            word.last    = 1'b0;
            found.push_back(word);
         end
         pad_held[i] = touched;
      end
      if (found.size() > 0) found[found.size()-1].last = 1'b1;
      foreach (found[k]) expected_presses.push_back(found[k]);
   endtask

   task automatic sender_gap(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // returns at the accepting edge with valid still high
   task automatic send_tick(input logic [31:0] now, input logic [15:0] r0,
                            input logic [15:0] r1, input logic [15:0] r2);
      if (!steady_tail && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 18));
      req_valid        <= 1'b1;
      req_time_ms      <= now;
      req_pad0_reading <= r0;
      req_pad1_reading <= r1;
      req_pad2_reading <= r2;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_presses(now, r0, r1, r2);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_presses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (index)
         CSR_ENABLE:    cfg_enable    = value[0];
         CSR_THRESHOLD: cfg_threshold = value;
         CSR_DEBOUNCE:  cfg_debounce  = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] enable_word, input logic [15:0] threshold,
                             input logic [15:0] debounce);
      drain_results();
      write_csr(CSR_ENABLE, enable_word);
      write_csr(CSR_THRESHOLD, threshold);
      write_csr(CSR_DEBOUNCE, debounce);
   endtask

   function automatic logic [15:0] pad_reading(input logic touched);
      if ($urandom_range(0, 7) == 0) return touched ? 16'hFFFF : cfg_threshold;
      if (!touched) return 16'($urandom_range(32'(cfg_threshold), 0));
      if (cfg_threshold == 16'hFFFF) return 16'hFFFF;
      return 16'($urandom_range(65535, 32'(cfg_threshold) + 1));
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_presses.size() == 0) begin
            $error("rsp word with nothing expected: action %0d show %0d",
                   rsp_action, rsp_show_number);
            error_count++;
         end else begin
            head_press = expected_presses.pop_front();
            check_field("action", head_press.action, rsp_action);
            check_field("show_number", head_press.show, rsp_show_number);
            check_field("variant_number", head_press.variant, rsp_variant_number);
            check_field("layout_number", head_press.layout, rsp_layout_number);
            check_field("reverse_flag", head_press.reverse, rsp_reverse_flag);
            check_field("mirror_flag", head_press.mirror, rsp_mirror_flag);
            check_field("last", head_press.last, rsp_last);
         end
      end
   end

   always begin
      @(posedge clock);
      if (!steady_tail && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      rsp_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clock);
   end

   // pads touched while disabled must leave no edge memory behind
   task automatic test_disabled_ticks();
      send_tick(32'd1000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_tick(32'd2000, 16'h0000, 16'h0000, 16'h0000);
      send_tick(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
   endtask

   task automatic test_debounce_edges();
      drain_results();
      write_csr(CSR_ENABLE, 16'h0003);
      send_tick(32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_tick(32'd100, 16'h0000, 16'h0000, 16'h0000);
      send_tick(32'd299, 16'h0001, 16'h0001, 16'h0001);
      send_tick(32'd299, 16'h0000, 16'h0000, 16'h0000);
      send_tick(32'd300, 16'h0001, 16'h8000, 16'hFFFF);
      send_tick(32'd301, 16'h0001, 16'h8000, 16'hFFFF);
      send_tick(32'd302, 16'h0000, 16'h0000, 16'h0000);
      send_tick(32'd599, 16'h7FFF, 16'h0000, 16'h0000);
      send_tick(32'd600, 16'h0000, 16'h0000, 16'h0000);
      send_tick(32'd601, 16'h7FFF, 16'h5555, 16'hAAAA);
   endtask

   task automatic test_threshold_and_wrap();
      set_config(16'h0001, 16'hFFFF, DEBOUNCE_RESET);
      send_tick(32'd5000, 16'h0000, 16'h0000, 16'h0000);
      send_tick(32'd6000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      set_config(16'h0001, 16'h1234, 16'h0000);
      send_tick(32'd7000, 16'h1234, 16'h1234, 16'h1234);
      send_tick(32'd7000, 16'h1235, 16'h1235, 16'h1235);
      send_tick(32'd7000, 16'h0000, 16'h0000, 16'h0000);
      send_tick(32'd7000, 16'hEDCB, 16'h1235, 16'h0000);
      set_config(16'h0001, 16'h0000, 16'hFFFF);
      send_tick(32'hFFFF_FFF0, 16'h0000, 16'h0000, 16'h0000);
      send_tick(32'hFFFF_FFF0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_tick(32'hFFFF_FFF1, 16'h0000, 16'h0000, 16'h0000);
      send_tick(32'h0000_FFEE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_tick(32'h0000_FFEE, 16'h0000, 16'h0000, 16'h0000);
      send_tick(32'h0000_FFEF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
   endtask

   // writes to the unused index must not disturb any register
   task automatic test_config_index();
      drain_results();
      write_csr(CSR_UNUSED, 16'h0000);
      write_csr(CSR_UNUSED, 16'hFFFF);
      send_tick(32'h0001_0000, 16'h0000, 16'h0000, 16'h0000);
      send_tick(32'h0002_0000, 16'h0001, 16'h0001, 16'h0001);
   endtask

   task automatic run_phase(input int count, input int max_step);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_tick($urandom(), 16'($urandom()), 16'($urandom()), 16'($urandom()));
         end else begin
            if ($urandom_range(0, 49) == 0) sim_ms = $urandom();
            sim_ms = sim_ms + $urandom_range(0, max_step);
            for (int p = 0; p < PAD_COUNT; p++)
               if ($urandom_range(0, 1) == 1) touch_plan[p] = ~touch_plan[p];
            send_tick(sim_ms, pad_reading(touch_plan[0]), pad_reading(touch_plan[1]),
                      pad_reading(touch_plan[2]));
         end
      end
   endtask

   task automatic test_random_phases();
      sim_ms = $urandom();
      set_config(16'h0001, 16'h0000, 16'h0000);
      run_phase(90, 50);
      set_config(16'h0001, 16'hFFFF, DEBOUNCE_RESET);
      run_phase(20, 400);
      set_config(16'h0001, 16'($urandom()), 16'($urandom_range(0, 255)));
      run_phase(100, 300);
      set_config(16'h0001, 16'h8000, 16'hFFFF);
      run_phase(40, 70000);
      set_config(16'hFFFE, 16'($urandom()), 16'd0);
      run_phase(15, 100);
      set_config(16'h0001, 16'($urandom()), DEBOUNCE_RESET);
      run_phase(100, 500);
   endtask

   task automatic test_steady_tail();
      set_config(16'h0001, 16'($urandom()), 16'd20);
      steady_tail = 1'b1;
      run_phase(80, 100);
   endtask

   initial begin
      foreach (press_stamp[k]) press_stamp[k] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_disabled_ticks();
      test_debounce_edges();
      test_threshold_and_wrap();
      test_config_index();
      test_random_phases();
      test_steady_tail();
      drain_results();
      if (error_count == 0)
         $display("touch_button_cycle_controller_core_tb OK");
      else
         $display("touch_button_cycle_controller_core_tb NOT OK");
      $finish;
   end

endmodule
